@@ rtl/rc_control_packet_builder_macros.svh @@
// Assertion macros shared by the checking code of the packet builder.
`ifndef RC_CONTROL_PACKET_BUILDER_MACROS_SVH
`define RC_CONTROL_PACKET_BUILDER_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define RCPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcpb check failed");

// Next-cycle implication, checked while out of reset
`define RCPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcpb check failed");

`endif

@@ rtl/rcpb_pkg.sv @@
package rcpb_pkg;

    // Packet geometry
    localparam int PKT_BYTES  = 15;
    localparam int BODY_BYTES = 14;
    localparam logic [3:0] SUM_IDX = 4'd14;

    // Variant codes
    localparam logic [2:0] SUB_BASE = 3'd0;
    localparam logic [2:0] SUB_VAR1 = 3'd1;
    localparam logic [2:0] SUB_VAR2 = 3'd2;
    localparam logic [2:0] SUB_VAR3 = 3'd3;
    localparam logic [2:0] SUB_VAR4 = 3'd4;

    // Request codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_BIND = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SUB   = 2'd0;
    localparam logic [1:0] CFG_TELEM = 2'd1;
    localparam logic [1:0] CFG_TXID  = 2'd2;

    localparam logic [6:0] BIND_CHAN_WIDE = 7'd10;

    typedef struct packed {
        logic              command;
        logic signed [11:0] rudder;
        logic signed [11:0] elevator;
        logic signed [11:0] throttle;
        logic signed [11:0] aileron;
        logic [8:0]        switch_bits;
    } req_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic [6:0] radio_channel;
        logic       last;
    } rsp_t;

    // Configuration as seen by the front end
    typedef struct packed {
        logic [2:0]  sub_protocol;
        logic        telemetry_on;
        logic [31:0] tx_id;
    } cfg_t;

    // Built packet body (checksum excluded) and its channel
    typedef struct packed {
        logic [BODY_BYTES-1:0][7:0] body;
        logic [6:0]                 chan;
    } pkt_t;

    // Offset and clamp to 0..2048, then halve: 0..1024
    function automatic logic [10:0] stick10(input logic signed [11:0] s);
        logic signed [12:0] v;
        logic [10:0]        r;
        v = {s[11], s} + 13'sd1024;
        if (v < 13'sd0)
            r = 11'd0;
        else if (v > 13'sd2048)
            r = 11'd1024;
        else
            r = v[11:1];
        return r;
    endfunction

    // High byte carries trim (or the fixed centre), low byte the value
    function automatic logic [15:0] put_stick(input logic [10:0] val, input logic trim);
        logic [7:0] hi;
        hi = {5'd0, val[10:8]} + (trim ? {val[9:4], 2'b00} : 8'h7C);
        return {hi, val[7:0]};
    endfunction

    function automatic logic [6:0] hop_channel(input logic [7:0] id0, input logic [1:0] k);
        logic [6:0] c1;
        logic [6:0] r;
        c1 = {2'd0, id0[4:0]} + 7'h10;
        unique case (k)
            2'd0:    r = 7'd0;
            2'd1:    r = c1;
            2'd2:    r = c1 + 7'h20;
            default: r = c1 + 7'h40;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/rcpb_if.sv @@
// Valid/ready channel carrying one payload per transaction
interface rcpb_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rcpb_front.sv @@
module rcpb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  rcpb_pkg::cfg_t cfg,
    rcpb_if.sink          req,
    input  logic          q_full,
    output logic          push,
    output rcpb_pkg::pkt_t pkt
);
    import rcpb_pkg::*;

    logic [1:0] hop_reg;
    logic [1:0] hop_next;
    logic       wide;
    logic       trim;
    logic [7:0] id [4];
    logic [7:0] f2;
    logic [7:0] f3;
    logic [8:0] sw;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    assign id[0] = cfg.tx_id[7:0];
    assign id[1] = cfg.tx_id[15:8];
    assign id[2] = cfg.tx_id[23:16];
    assign id[3] = cfg.tx_id[31:24];

    assign wide = (cfg.sub_protocol == SUB_VAR2) || (cfg.sub_protocol == SUB_VAR3);
    assign sw   = req.payload.switch_bits;
    // headless or trim-off switch disables trim
    assign trim = !(sw[4] || sw[6]);

    // flag bytes
    assign f2 = {2'b00, sw[2], sw[3], sw[0], 1'b0, sw[4], sw[1]};
    assign f3 = {sw[5], 1'b0, sw[7], 1'b0, sw[8], sw[8], 2'b00};

    // packet assembly
    always_comb
    begin
        pkt = '0;
        if (req.payload.command == CMD_BIND)
        begin
            pkt.body[0] = cfg.telemetry_on ? 8'hA3 : 8'hA4;
            pkt.body[1] = id[0];
            pkt.body[2] = id[1];
            pkt.body[3] = id[2];
            pkt.body[4] = id[3];
            pkt.body[5] = id[0];
            pkt.body[6] = {1'b0, hop_channel(id[0], 2'd0)};
            pkt.body[7] = {1'b0, hop_channel(id[0], 2'd1)};
            pkt.body[8] = {1'b0, hop_channel(id[0], 2'd2)};
            pkt.body[9] = {1'b0, hop_channel(id[0], 2'd3)};
            unique case (cfg.sub_protocol)
                SUB_VAR2:
                begin
                    pkt.body[10] = 8'h00;
                    pkt.body[11] = 8'h00;
                end
                SUB_VAR3:
                begin
                    pkt.body[10] = 8'h30;
                    pkt.body[11] = 8'h01;
                end
                SUB_VAR4:
                begin
                    pkt.body[10] = 8'hC8;
                    pkt.body[11] = 8'h99;
                end
                default:
                begin
                    pkt.body[10] = id[0];
                    pkt.body[11] = id[1];
                end
            endcase
            pkt.chan = wide ? BIND_CHAN_WIDE : 7'd0;
        end
        else
        begin
            pkt.body[0] = wide ? 8'hA6 : 8'hA5;
            pkt.body[1] = 8'hFA;
            pkt.body[2] = f2;
            pkt.body[3] = f3;
            {pkt.body[4], pkt.body[5]}   = put_stick(stick10(req.payload.aileron), trim);
            {pkt.body[6], pkt.body[7]}   = put_stick(stick10(req.payload.elevator), trim);
            {pkt.body[8], pkt.body[9]}   = put_stick(stick10(req.payload.throttle), 1'b0);
            {pkt.body[10], pkt.body[11]} = put_stick(stick10(req.payload.rudder), trim);
            pkt.chan = hop_channel(id[0], hop_reg);
        end

        // variant tail
        unique case (cfg.sub_protocol)
            SUB_VAR2:
            begin
                pkt.body[12] = 8'h00;
                pkt.body[13] = 8'h00;
            end
            SUB_VAR3:
            begin
                pkt.body[12] = 8'hE0;
                pkt.body[13] = 8'h2E;
            end
            SUB_VAR4:
            begin
                pkt.body[12] = 8'h37;
                pkt.body[13] = 8'hED;
            end
            SUB_VAR1:
            begin
                pkt.body[12] = id[2];
                pkt.body[13] = 8'h34;
            end
            default:
            begin
                pkt.body[12] = id[2];
                pkt.body[13] = 8'h0A;
            end
        endcase
    end

    // hop advances on each data transaction
    assign hop_next = (push && req.payload.command == CMD_DATA) ? hop_reg + 2'd1 : hop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hop_reg <= 2'd0;
        else
            hop_reg <= hop_next;
    end

endmodule

@@ rtl/rcpb_queue.sv @@
module rcpb_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rcpb_pkg::pkt_t push_pkt,
    input  logic           pop,
    output logic           full,
    output logic           avail,
    output rcpb_pkg::pkt_t head
);
    import rcpb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pkt_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == CNT_FULL);
    assign avail = (cnt_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_pkt;
    end

endmodule

@@ rtl/rcpb_back.sv @@
module rcpb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_avail,
    input  rcpb_pkg::pkt_t q_head,
    output logic           pop,
    rcpb_if.source         rsp
);
    import rcpb_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    pkt_t       pkt_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    rsp_t       out_reg;
    logic       advance;
    logic       finish;
    logic [7:0] cur_byte;

    // a byte moves into the output register whenever it is free
    assign advance  = busy_reg && (!out_valid_reg || rsp.ready);
    assign finish   = advance && (idx_reg == SUM_IDX);
    assign pop      = q_avail && (!busy_reg || finish);
    assign cur_byte = (idx_reg == SUM_IDX) ? sum_reg : pkt_reg.body[idx_reg];

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 4'd1;
            sum_next       = sum_reg + cur_byte;
            if (finish)
                busy_next = 1'b0;
        end
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
            sum_next  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            pkt_reg <= q_head;
        if (advance)
        begin
            out_reg.packet_byte   <= cur_byte;
            out_reg.radio_channel <= pkt_reg.chan;
            out_reg.last          <= (idx_reg == SUM_IDX);
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

@@ rtl/rc_control_packet_builder.sv @@
// Packet builder for a four-channel hopping RC link.
// req: one transaction per packet request (bind or data) with four stick
//      values and nine switch bits. rsp: fifteen transactions per packet,
//      one packet byte each, with the radio channel; last marks byte 14,
//      the 8-bit additive checksum.
// cfg_we/cfg_index/cfg_data write sub_protocol (0), telemetry_on (1) and
//      tx_id (2); write only while no packet is in flight.
// A request is written into the packet queue, then into the serialiser's
//      packet register, and its first byte then into the output register.
// Throughput: one byte per cycle while rsp is ready, set by the byte
//      serialiser; requests are taken while earlier packets are still
//      being sent, up to the depth of the packet queue.
// Reset clears the hop index, the configuration registers, the queue and the output.
// A stalled rsp holds its byte; the serialiser waits, the queue fills
//      and req.ready drops once it is full.
module rc_control_packet_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    rcpb_if.sink        req,
    rcpb_if.source      rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rcpb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    pkt_t built_pkt;
    pkt_t head_pkt;
    logic push;
    logic pop;
    logic q_full;
    logic q_avail;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SUB:   cfg_next.sub_protocol = cfg_data[2:0];
                CFG_TELEM: cfg_next.telemetry_on = cfg_data[0];
                CFG_TXID:  cfg_next.tx_id        = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    rcpb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .pkt    (built_pkt)
    );

    rcpb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (built_pkt),
        .pop      (pop),
        .full     (q_full),
        .avail    (q_avail),
        .head     (head_pkt)
    );

    rcpb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_head  (head_pkt),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

@@ rtl/rcpb_checker.sv @@
`include "rc_control_packet_builder_macros.svh"

module rcpb_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  rcpb_pkg::rsp_t rsp_payload
);
    import rcpb_pkg::*;

    logic       xfer;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [6:0] chan_reg;

    assign xfer = rsp_valid && rsp_ready;

    // byte position and running sum of the packet on the wire
    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (xfer)
        begin
            if (rsp_payload.last)
            begin
                cnt_next = 4'd0;
                sum_next = 8'd0;
            end
            else
            begin
                cnt_next = cnt_reg + 4'd1;
                sum_next = sum_reg + rsp_payload.packet_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            sum_reg  <= 8'd0;
            chan_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            if (xfer)
                chan_reg <= rsp_payload.radio_channel;
        end
    end

    `RCPB_ASSERT_NEXT(a_stall_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
    `RCPB_ASSERT_NOW(a_last_pos, clk, rst_n, xfer, rsp_payload.last == (cnt_reg == SUM_IDX))
    `RCPB_ASSERT_NOW(a_checksum, clk, rst_n, xfer && rsp_payload.last, rsp_payload.packet_byte == sum_reg)
    `RCPB_ASSERT_NOW(a_chan_const, clk, rst_n, rsp_valid && (cnt_reg != 4'd0), rsp_payload.radio_channel == chan_reg)

endmodule

bind rc_control_packet_builder rcpb_checker u_rcpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
